// ===== src/hrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrsp_pkg
// types and constants shared by the request stream parser modules
// ----------------------------------------------------------------------------
package hrsp_pkg;

    localparam int LENGTH_WIDTH = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;

    // output item kinds
    localparam logic [1:0] KIND_METHOD  = 2'd0;
    localparam logic [1:0] KIND_PATH    = 2'd1;
    localparam logic [1:0] KIND_BODY    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // summary status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_UNSAFE    = 2'd2;

    // classified item handed from the front part to the back part
    typedef struct packed {
        logic                    emit_byte;
        logic [1:0]              kind;
        logic [7:0]              data;
        logic                    emit_summary;
        logic [1:0]              status;
        logic [LENGTH_WIDTH-1:0] body_length;
        logic [LENGTH_WIDTH-1:0] declared_length;
    } hrsp_op_t;

endpackage

// ===== src/http_request_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// http_request_stream_parser_top
// streaming request parser: method, path and body bytes plus a summary item
// ----------------------------------------------------------------------------
//  channel  signals                                          direction
//  in       in_valid in_stall data_byte last_byte             into block
//  out      out_valid out_stall out_byte out_kind status
//           body_length declared_length last_result           out of block
//
//  one byte accepted per cycle while in_stall is low; the front parser updates its state on each accepted byte
//  a last byte that is also passed on yields two result items, its byte and then the summary
//  a four-entry queue sits between front parser and output register
//  in_stall rises only when that queue is full
//  rst_n clears parse state, queue and output register at once
// ----------------------------------------------------------------------------
module http_request_stream_parser_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_byte,
    output logic [1:0]                        out_kind,
    output logic [1:0]                        status,
    output logic [hrsp_pkg::LENGTH_WIDTH-1:0] body_length,
    output logic [hrsp_pkg::LENGTH_WIDTH-1:0] declared_length,
    output logic                              last_result
);
    import hrsp_pkg::*;

    hrsp_op_t front_op, head_op;
    logic     in_fire, q_pop, q_ne, q_nf;

    assign in_stall = !q_nf;
    assign in_fire  = in_valid && q_nf;

    hrsp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .op        (front_op)
    );

    hrsp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_op   (front_op),
        .pop       (q_pop),
        .head_op   (head_op),
        .not_empty (q_ne),
        .not_full  (q_nf)
    );

    hrsp_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_ne),
        .q_op            (head_op),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .out_kind        (out_kind),
        .status          (status),
        .body_length     (body_length),
        .declared_length (declared_length),
        .last_result     (last_result)
    );

endmodule

// ===== src/hrsp_front.sv =====
// ----------------------------------------------------------------------------
// hrsp_front
// accepts request bytes, tracks the parse phase and classifies each byte
// ----------------------------------------------------------------------------
module hrsp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output hrsp_pkg::hrsp_op_t op
);
    import hrsp_pkg::*;

    typedef enum logic [2:0] {
        PH_METHOD, PH_PATH, PH_LINE, PH_HEADERS, PH_BODY, PH_UNSAFE
    } phase_t;

    localparam logic [4:0] NM_SKIP   = 5'd15;
    localparam logic [4:0] NM_DIGITS = 5'd16;
    localparam logic [4:0] NM_DEAD   = 5'd31;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    phase_t                  phase_reg, phase_next;
    logic [LENGTH_WIDTH-1:0] length_reg, length_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic [4:0]              nm_reg, nm_next;
    logic [2:0]              crlf_reg, crlf_next;
    logic [1:0]              dot_reg, dot_next;
    logic                    started_reg, started_next;
    logic                    badstart_reg, badstart_next;
    logic                    query_reg, query_next;
    logic                    dotdot_reg, dotdot_next;
    logic                    found_reg, found_next;

    // header name character at the current match position
    function automatic logic [7:0] name_char(input logic [4:0] p);
        logic [7:0] c;
        begin
            case (p)
                5'd0:    c = "c";
                5'd1:    c = "o";
                5'd2:    c = "n";
                5'd3:    c = "t";
                5'd4:    c = "e";
                5'd5:    c = "n";
                5'd6:    c = "t";
                5'd7:    c = "-";
                5'd8:    c = "l";
                5'd9:    c = "e";
                5'd10:   c = "n";
                5'd11:   c = "g";
                5'd12:   c = "t";
                5'd13:   c = "h";
                5'd14:   c = ":";
                default: c = 8'd0;
            endcase
            return c;
        end
    endfunction

    logic [7:0]              lower;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [LENGTH_WIDTH+3:0] times_ten;
    logic [LENGTH_WIDTH+4:0] acc_sum;
    logic [2:0]              crlf_k;
    phase_t                  end_phase;

    always_comb
    begin
        lower     = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
        is_digit  = data_byte >= "0" && data_byte <= "9";
        digit     = data_byte[3:0];
        times_ten = {1'b0, length_reg, 3'b000} + {3'b000, length_reg, 1'b0};
        acc_sum   = {1'b0, times_ten} + {{(LENGTH_WIDTH+1){1'b0}}, digit};
    end

    // next state and classification
    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        nm_next       = nm_reg;
        crlf_next     = crlf_reg;
        dot_next      = dot_reg;
        started_next  = started_reg;
        badstart_next = badstart_reg;
        query_next    = query_reg;
        dotdot_next   = dotdot_reg;
        found_next    = found_reg;
        crlf_k        = 3'd0;
        op            = '0;
        op.data       = data_byte;

        case (phase_reg)
            PH_METHOD:
            begin
                if (data_byte == " ")
                begin
                    phase_next    = PH_PATH;
                    started_next  = 1'b0;
                    badstart_next = 1'b0;
                    query_next    = 1'b0;
                    dotdot_next   = 1'b0;
                    dot_next      = 2'd0;
                end
                else
                begin
                    op.emit_byte = 1'b1;
                    op.kind      = KIND_METHOD;
                end
            end
            PH_PATH:
            begin
                if (data_byte == " ")
                begin
                    if (!started_reg || badstart_reg || dotdot_reg
                        || (!query_reg && dot_reg == 2'd2))
                        phase_next = PH_UNSAFE;
                    else
                        phase_next = PH_LINE;
                    crlf_next = 3'd0;
                end
                else if (query_reg)
                begin
                    // query string dropped
                end
                else if (data_byte == "?")
                begin
                    if (dot_reg == 2'd2)
                        dotdot_next = 1'b1;
                    query_next = 1'b1;
                end
                else
                begin
                    op.emit_byte = 1'b1;
                    op.kind      = KIND_PATH;
                    if (!started_reg)
                    begin
                        started_next  = 1'b1;
                        badstart_next = data_byte != "/";
                    end
                    if (data_byte == "/")
                    begin
                        if (dot_reg == 2'd2)
                            dotdot_next = 1'b1;
                        dot_next = 2'd0;
                    end
                    else if (data_byte == ".")
                        dot_next = (dot_reg < 2'd2) ? dot_reg + 2'd1 : 2'd3;
                    else
                        dot_next = 2'd3;
                end
            end
            PH_LINE:
            begin
                if (data_byte == 8'h0d)
                    crlf_next = 3'd1;
                else if (data_byte == 8'h0a && crlf_reg == 3'd1)
                begin
                    phase_next = PH_HEADERS;
                    crlf_next  = 3'd0;
                    nm_next    = 5'd0;
                end
                else
                    crlf_next = 3'd0;
            end
            PH_HEADERS:
            begin
                // header name match and length digits
                if (nm_reg < 5'd15)
                begin
                    if (lower == name_char(nm_reg))
                    begin
                        nm_next = nm_reg + 5'd1;
                        if (nm_reg == 5'd14)
                            found_next = 1'b1;
                    end
                    else
                        nm_next = NM_DEAD;
                end
                else if (nm_reg == NM_SKIP)
                begin
                    if (is_digit)
                    begin
                        length_next = {{(LENGTH_WIDTH-4){1'b0}}, digit};
                        nm_next     = NM_DIGITS;
                    end
                    else if (data_byte != " " && data_byte != 8'h09)
                        nm_next = NM_DEAD;
                end
                else if (nm_reg == NM_DIGITS)
                begin
                    if (is_digit)
                    begin
                        if (acc_sum[LENGTH_WIDTH+4:LENGTH_WIDTH] != '0)
                            length_next = LEN_MAX;
                        else
                            length_next = acc_sum[LENGTH_WIDTH-1:0];
                    end
                    else
                        nm_next = NM_DEAD;
                end
                // blank line search
                if (data_byte == 8'h0d)
                    crlf_k = (crlf_reg == 3'd0 || crlf_reg == 3'd2) ? crlf_reg + 3'd1 : 3'd1;
                else if (data_byte == 8'h0a && (crlf_reg == 3'd1 || crlf_reg == 3'd3))
                    crlf_k = crlf_reg + 3'd1;
                else
                    crlf_k = 3'd0;
                if (crlf_k == 3'd4)
                begin
                    phase_next = PH_BODY;
                    crlf_next  = 3'd0;
                end
                else
                begin
                    crlf_next = crlf_k;
                    if (crlf_k == 3'd2 && !found_next)
                        nm_next = 5'd0;
                end
            end
            PH_BODY:
            begin
                if (count_reg < length_reg)
                begin
                    op.emit_byte = 1'b1;
                    op.kind      = KIND_BODY;
                    count_next   = count_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // summary on the last byte, then back to reset state
        end_phase = phase_next;
        if (last_byte)
        begin
            op.emit_summary = 1'b1;
            if (end_phase == PH_BODY)
            begin
                op.status          = STATUS_OK;
                op.body_length     = count_next;
                op.declared_length = length_next;
            end
            else
                op.status = (end_phase == PH_UNSAFE) ? STATUS_UNSAFE : STATUS_MALFORMED;
            phase_next    = PH_METHOD;
            length_next   = '0;
            count_next    = '0;
            nm_next       = 5'd0;
            crlf_next     = 3'd0;
            dot_next      = 2'd0;
            started_next  = 1'b0;
            badstart_next = 1'b0;
            query_next    = 1'b0;
            dotdot_next   = 1'b0;
            found_next    = 1'b0;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_METHOD;
            length_reg   <= '0;
            count_reg    <= '0;
            nm_reg       <= 5'd0;
            crlf_reg     <= 3'd0;
            dot_reg      <= 2'd0;
            started_reg  <= 1'b0;
            badstart_reg <= 1'b0;
            query_reg    <= 1'b0;
            dotdot_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            nm_reg       <= nm_next;
            crlf_reg     <= crlf_next;
            dot_reg      <= dot_next;
            started_reg  <= started_next;
            badstart_reg <= badstart_next;
            query_reg    <= query_next;
            dotdot_reg   <= dotdot_next;
            found_reg    <= found_next;
        end
    end

    // body count never runs past the declared length
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= length_reg)
        else $error("body count beyond length");
    // a blank-line match is only tracked while in the header block
    assert property (@(posedge clk) disable iff (!rst_n)
        (crlf_reg > 3'd1) |-> phase_reg == PH_HEADERS)
        else $error("crlf tracking outside headers");
    // the last byte always returns the parser to the method phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_byte) |=> phase_reg == PH_METHOD)
        else $error("no reset after last byte");

endmodule

// ===== src/hrsp_queue.sv =====
// ----------------------------------------------------------------------------
// hrsp_queue
// short queue of classified items between the front and back parts
// ----------------------------------------------------------------------------
module hrsp_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hrsp_pkg::hrsp_op_t push_op,
    input  logic               pop,
    output hrsp_pkg::hrsp_op_t head_op,
    output logic               not_empty,
    output logic               not_full
);
    import hrsp_pkg::*;

    hrsp_op_t          mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   cnt_reg;

    assign not_empty = cnt_reg != '0;
    assign not_full  = cnt_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign head_op   = mem_reg[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_op;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> not_full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

// ===== src/hrsp_back.sv =====
// ----------------------------------------------------------------------------
// hrsp_back
// turns queued items into up to two result items through an output register
// ----------------------------------------------------------------------------
module hrsp_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  hrsp_pkg::hrsp_op_t                  q_op,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_byte,
    output logic [1:0]                          out_kind,
    output logic [1:0]                          status,
    output logic [hrsp_pkg::LENGTH_WIDTH-1:0]   body_length,
    output logic [hrsp_pkg::LENGTH_WIDTH-1:0]   declared_length,
    output logic                                last_result
);
    import hrsp_pkg::*;

    logic byte_done_reg, byte_done_next;
    logic load;
    logic send_byte;
    logic has_work;
    logic finish;

    logic                    valid_reg;
    logic [7:0]              byte_reg;
    logic [1:0]              kind_reg, status_reg;
    logic [LENGTH_WIDTH-1:0] blen_reg, clen_reg;
    logic                    lastr_reg;

    // next piece of the head item: its byte first, then its summary
    always_comb
    begin
        send_byte = q_op.emit_byte && !byte_done_reg;
        has_work  = q_valid && (send_byte || q_op.emit_summary);
        load      = has_work && (!valid_reg || !out_stall);
        finish    = load && (!send_byte || !q_op.emit_summary);
        q_pop     = finish || (q_valid && !q_op.emit_byte && !q_op.emit_summary);
        byte_done_next = byte_done_reg;
        if (q_pop)
            byte_done_next = 1'b0;
        else if (load)
            byte_done_next = 1'b1;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            byte_done_reg <= 1'b0;
        end
        else
        begin
            byte_done_reg <= byte_done_next;
            if (load)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= send_byte ? q_op.data : 8'd0;
            kind_reg   <= send_byte ? q_op.kind : KIND_SUMMARY;
            status_reg <= send_byte ? STATUS_OK : q_op.status;
            blen_reg   <= send_byte ? '0 : q_op.body_length;
            clen_reg   <= send_byte ? '0 : q_op.declared_length;
            lastr_reg  <= !send_byte;
        end
    end

    assign out_valid       = valid_reg;
    assign out_byte        = byte_reg;
    assign out_kind        = kind_reg;
    assign status          = status_reg;
    assign body_length     = blen_reg;
    assign declared_length = clen_reg;
    assign last_result     = lastr_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_result) |-> out_kind == KIND_SUMMARY)
        else $error("summary flag on a byte item");
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_done_reg |-> (q_valid && q_op.emit_summary))
        else $error("split item lost its summary");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> valid_reg)
        else $error("stalled result dropped");

endmodule
